@@ rtl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

  localparam int THR_W = 31;

  typedef logic [THR_W-1:0] thr_t;

endpackage
`default_nettype wire

@@ rtl/mi3_ifs.sv @@
`default_nettype none
interface mi3_in_if #(parameter int ELEM_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] in_r0c0;
  logic signed [ELEM_WIDTH-1:0] in_r0c1;
  logic signed [ELEM_WIDTH-1:0] in_r0c2;
  logic signed [ELEM_WIDTH-1:0] in_r1c0;
  logic signed [ELEM_WIDTH-1:0] in_r1c1;
  logic signed [ELEM_WIDTH-1:0] in_r1c2;
  logic signed [ELEM_WIDTH-1:0] in_r2c0;
  logic signed [ELEM_WIDTH-1:0] in_r2c1;
  logic signed [ELEM_WIDTH-1:0] in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_out_if #(parameter int ELEM_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] inv_r0c0;
  logic signed [ELEM_WIDTH-1:0] inv_r0c1;
  logic signed [ELEM_WIDTH-1:0] inv_r0c2;
  logic signed [ELEM_WIDTH-1:0] inv_r1c0;
  logic signed [ELEM_WIDTH-1:0] inv_r1c1;
  logic signed [ELEM_WIDTH-1:0] inv_r1c2;
  logic signed [ELEM_WIDTH-1:0] inv_r2c0;
  logic signed [ELEM_WIDTH-1:0] inv_r2c1;
  logic signed [ELEM_WIDTH-1:0] inv_r2c2;
  logic                         singular;
  logic                         saturated;

  modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
                  input ready);
  modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
                output ready);
endinterface

interface mi3_cfg_if import mi3_pkg::*; ();
  logic valid;
  logic ready;
  thr_t det_threshold;

  modport source (output valid, det_threshold, input ready);
  modport sink (input valid, det_threshold, output ready);
endinterface
`default_nettype wire

@@ rtl/mi3_div_lane.sv @@
`default_nettype none
module mi3_div_lane #(
  parameter int W  = 32,
  parameter int XW = 131
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [XW-1:0] num,
  input  logic [XW-1:0] den,
  input  logic          neg,
  output logic [W-1:0]  quo,
  output logic          ovf,
  output logic          neg_o
);

  logic [XW-1:0] rem_r [W+1];
  logic [XW-1:0] dv_r  [W+1];
  logic [W-1:0]  q_r   [W+1];
  logic          ov_r  [W+1];
  logic          ng_r  [W+1];

  // quotient of W bits is enough unless num >= den * 2^W
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= num;
      dv_r[0]  <= den;
      q_r[0]   <= '0;
      ov_r[0]  <= (num >= (den << W));
      ng_r[0]  <= neg;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    localparam int J = W - k;
    logic [XW-1:0] dsh;
    logic [XW:0]   diff;

    assign dsh  = dv_r[k-1] << J;
    assign diff = {1'b0, rem_r[k-1]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= diff[XW] ? rem_r[k-1] : diff[XW-1:0];
        q_r[k]   <= q_r[k-1] | ({{(W-1){1'b0}}, ~diff[XW]} << J);
        dv_r[k]  <= dv_r[k-1];
        ov_r[k]  <= ov_r[k-1];
        ng_r[k]  <= ng_r[k-1];
      end
    end
  end

  assign quo   = q_r[W];
  assign ovf   = ov_r[W];
  assign neg_o = ng_r[W];

endmodule
`default_nettype wire

@@ rtl/matrix3x3_inverse.sv @@
// Throughput: one matrix per cycle while the output skid entry is free; nine division lanes resolve one quotient bit
// per stage, and the cofactor and determinant multipliers are fully pipelined.
// Backpressure freezes the pipeline only once the output skid entry is occupied.
// Reset clears all valid bits and the skid entry and sets det_threshold to 1.
`default_nettype none
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic       clk,
  input logic       rst_n,
  mi3_in_if.sink    in_ch,
  mi3_out_if.source out_ch,
  mi3_cfg_if.sink   cfg_ch
);

  localparam int W    = ELEM_WIDTH;
  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int MW   = 2 * W + 1;
  localparam int DW   = 3 * W + 3;
  localparam int TW   = THR_W + 2 * FRAC_BITS;
  localparam int CMPW = (DW > TW) ? DW : TW;
  localparam int NSH  = 2 * FRAC_BITS + 1;
  localparam int NW0  = (CW + NSH > DW) ? CW + NSH : DW;
  localparam int NW   = NW0 + 1;
  localparam int XW   = (NW > DW + 1 + W) ? NW : DW + 1 + W;
  localparam int NPRE = 7;
  localparam int LD   = W + 1;
  localparam int NV   = NPRE + LD;

  logic ce;
  logic signed [W-1:0] m [3][3];

  logic [NV-1:0] v_r;
  logic [LD-1:0] sgl_r;
  thr_t          thr_r;

  logic signed [PW-1:0] pa_r [3][3];
  logic signed [PW-1:0] pb_r [3][3];
  logic signed [W-1:0]  m0a_r [3];
  logic signed [W-1:0]  m0b_r [3];
  logic signed [CW-1:0] cof1_r [3][3];
  logic signed [CW-1:0] cof2_r [3][3];
  logic signed [CW-1:0] cof3_r [3][3];
  logic signed [CW-1:0] cof4_r [3][3];
  logic signed [MW-1:0] plo_r [3];
  logic signed [MW-1:0] phi_r [3];
  logic signed [DW-1:0] trm_r [3];
  logic signed [DW-1:0] det_r;
  logic [DW-1:0]        adet_r;
  logic [CW-1:0]        acof_r [3][3];
  logic                 neg5_r [3][3];
  logic [XW-1:0]        num_r [3][3];
  logic [XW-1:0]        den_r;
  logic                 neg6_r [3][3];
  logic                 sing6_r;

  logic [W-1:0] quo [3][3];
  logic         ovf [3][3];
  logic         lneg [3][3];
  logic [W-1:0] res [3][3];
  logic [8:0]   clipv;
  logic         e_v;
  logic         e_sing;
  logic         e_sat;

  logic [W-1:0] o_val_r [3][3];
  logic         o_sing_r;
  logic         o_sat_r;
  logic         o_v_r;
  logic [W-1:0] s_val_r [3][3];
  logic         s_sing_r;
  logic         s_sat_r;
  logic         s_v_r;

  assign m[0][0] = in_ch.in_r0c0;
  assign m[0][1] = in_ch.in_r0c1;
  assign m[0][2] = in_ch.in_r0c2;
  assign m[1][0] = in_ch.in_r1c0;
  assign m[1][1] = in_ch.in_r1c1;
  assign m[1][2] = in_ch.in_r1c2;
  assign m[2][0] = in_ch.in_r2c0;
  assign m[2][1] = in_ch.in_r2c1;
  assign m[2][2] = in_ch.in_r2c2;

  // advance the whole pipeline while the skid entry is free
  assign ce          = !s_v_r;
  assign in_ch.ready = ce;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= thr_t'(1);
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.det_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[NV-2:0], in_ch.valid};
    end
  end

  // cofactor products, cyclic index form carries the sign
  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;

      always_ff @(posedge clk) begin
        if (ce) begin
          pa_r[r][c]   <= PW'(m[R1][C1]) * PW'(m[R2][C2]);
          pb_r[r][c]   <= PW'(m[R1][C2]) * PW'(m[R2][C1]);
          cof1_r[r][c] <= CW'(pa_r[r][c]) - CW'(pb_r[r][c]);
          cof2_r[r][c] <= cof1_r[r][c];
          cof3_r[r][c] <= cof2_r[r][c];
          cof4_r[r][c] <= cof3_r[r][c];
          acof_r[r][c] <= cof4_r[r][c][CW-1] ? $unsigned(-cof4_r[r][c])
                                             : $unsigned(cof4_r[r][c]);
          // output (r,c) takes the adjugate entry, cofactor (c,r)
          neg5_r[r][c] <= cof4_r[c][r][CW-1] ^ det_r[DW-1];
          num_r[r][c]  <= (XW'(acof_r[c][r]) << NSH) + XW'(adet_r);
          neg6_r[r][c] <= neg5_r[r][c];
        end
      end

      mi3_div_lane #(.W(W), .XW(XW)) u_lane (
        .clk   (clk),
        .ce    (ce),
        .num   (num_r[r][c]),
        .den   (den_r),
        .neg   (neg6_r[r][c]),
        .quo   (quo[r][c]),
        .ovf   (ovf[r][c]),
        .neg_o (lneg[r][c])
      );

      logic [W-1:0] lim;
      logic [W-1:0] mag;
      logic         clip;

      assign lim  = lneg[r][c] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      assign clip = ovf[r][c] || (quo[r][c] > lim);
      assign mag  = clip ? lim : quo[r][c];
      assign res[r][c]       = e_sing ? '0 : (lneg[r][c] ? (~mag + 1'b1) : mag);
      assign clipv[r*3 + c]  = clip;
    end
  end

  // determinant as row 0 dotted with its cofactors, each product split in halves
  for (genvar c = 0; c < 3; c++) begin : g_det
    always_ff @(posedge clk) begin
      if (ce) begin
        m0a_r[c] <= m[0][c];
        m0b_r[c] <= m0a_r[c];
        plo_r[c] <= MW'(m0b_r[c]) * MW'($signed({1'b0, cof1_r[0][c][W-1:0]}));
        phi_r[c] <= MW'(m0b_r[c]) * MW'($signed(cof1_r[0][c][CW-1:W]));
        trm_r[c] <= (DW'(phi_r[c]) <<< W) + DW'(plo_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      det_r   <= trm_r[0] + trm_r[1] + trm_r[2];
      adet_r  <= det_r[DW-1] ? $unsigned(-det_r) : $unsigned(det_r);
      den_r   <= XW'(adet_r) << 1;
      sing6_r <= (adet_r == '0) ||
                 (CMPW'(adet_r) < (CMPW'(thr_r) << (2 * FRAC_BITS)));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sgl_r <= {sgl_r[LD-2:0], sing6_r};
    end
  end

  assign e_v    = v_r[NV-1];
  assign e_sing = sgl_r[LD-1];
  assign e_sat  = !e_sing && (|clipv);

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (s_v_r) begin
      if (out_ch.ready) begin
        s_v_r <= 1'b0;
      end
    end else if (o_v_r && !out_ch.ready) begin
      s_v_r <= e_v;
    end else begin
      o_v_r <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v_r) begin
      if (out_ch.ready) begin
        o_val_r  <= s_val_r;
        o_sing_r <= s_sing_r;
        o_sat_r  <= s_sat_r;
      end
    end else if (o_v_r && !out_ch.ready) begin
      s_val_r  <= res;
      s_sing_r <= e_sing;
      s_sat_r  <= e_sat;
    end else begin
      o_val_r  <= res;
      o_sing_r <= e_sing;
      o_sat_r  <= e_sat;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.inv_r0c0  = o_val_r[0][0];
  assign out_ch.inv_r0c1  = o_val_r[0][1];
  assign out_ch.inv_r0c2  = o_val_r[0][2];
  assign out_ch.inv_r1c0  = o_val_r[1][0];
  assign out_ch.inv_r1c1  = o_val_r[1][1];
  assign out_ch.inv_r1c2  = o_val_r[1][2];
  assign out_ch.inv_r2c0  = o_val_r[2][0];
  assign out_ch.inv_r2c1  = o_val_r[2][1];
  assign out_ch.inv_r2c2  = o_val_r[2][2];
  assign out_ch.singular  = o_sing_r;
  assign out_ch.saturated = o_sat_r;

endmodule
`default_nettype wire
